@@ rtl/core/shimmer_pkg.sv @@
// shared constants, types and the sine table builder of the shimmer highlight core
`timescale 1ns / 1ps

package shimmer_pkg;

  // coordinate and phase formats
  localparam int COORD_BITS     = 12;
  localparam int FRAC_BITS      = 24;
  localparam int DIV_W          = COORD_BITS + FRAC_BITS;
  localparam int DEN_W          = 13;
  localparam int PHASE_W        = 24;
  localparam int TIME_W         = 32;

  // sine table
  localparam int SINE_DEPTH_LOG = 10;
  localparam int SINE_DEPTH     = 1 << SINE_DEPTH_LOG;
  localparam int SINE_ADDR_W    = SINE_DEPTH_LOG + 1;
  localparam int SINE_MAG_W     = 15;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // series divisors (2n)(2n+1) as reciprocals: floor(x / d) = (x * SER_RECIP) >> SER_SHIFT,
  // exact for every series term, which stays below 2^32
  localparam int SER_SHIFT = 40;
  localparam longint unsigned SER_RECIP [6] = '{
    ((64'd1 << SER_SHIFT) + 64'd5)   / 64'd6,
    ((64'd1 << SER_SHIFT) + 64'd19)  / 64'd20,
    ((64'd1 << SER_SHIFT) + 64'd41)  / 64'd42,
    ((64'd1 << SER_SHIFT) + 64'd71)  / 64'd72,
    ((64'd1 << SER_SHIFT) + 64'd109) / 64'd110,
    ((64'd1 << SER_SHIFT) + 64'd155) / 64'd156
  };

  // shimmer factor, signed Q15
  localparam int FAC_W          = 18;
  localparam int FAC_OFFSET     = 9830;

  // coefficients in turns, Q32, split into a low and a high part
  localparam int K_W            = 40;
  localparam int K_SPLIT        = 20;
  localparam logic [K_W-1:0] K_T6    = 40'd4101391653;
  localparam logic [K_W-1:0] K_S180  = 40'd123041749604;
  localparam logic [K_W-1:0] K_T700  = 40'd478495692904;
  localparam logic [K_W-1:0] K_U450  = 40'd307604374009;
  localparam logic [K_W-1:0] K_U190  = 40'd129877402360;
  localparam logic [K_W-1:0] K_V30   = 40'd20506958267;
  localparam logic [K_W-1:0] K_T1080 = 40'd738455567205;

  // coordinate products are cut into four partial products
  localparam int U_LO_W         = (DIV_W + 1) / 2;
  localparam int U_HI_W         = DIV_W - U_LO_W;
  localparam int PP_W           = U_LO_W + K_SPLIT;
  localparam int CPROD_W        = 32 + PHASE_W;

  // channel lift: floor(x / 255) as (x * RECIP_255) >> RECIP_SHIFT for x below 2^17
  localparam int RECIP_SHIFT    = 25;
  localparam logic [17:0] RECIP_255 = 18'd131587;

  // cycles from the accepting edge to the edge that loads the result registers
  localparam int PIPE_LAT       = DIV_W + 10;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_TIME_VALUE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic                   neg;
    logic [SINE_ADDR_W-1:0] addr;
  } sin_addr_t;

  typedef logic [SINE_MAG_W-1:0] sine_rom_t [SINE_DEPTH+1];

  // quarter-wave table, 7-term series in Q30, rounded to Q15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    logic [79:0]       qp;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (longint'(k) * PI_HALF_Q30) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        qp   = 80'(term) * 80'(SER_RECIP[n-1]);
        term = qp[SER_SHIFT +: 64];
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > 64'sd1073741824) begin
        sum = 64'sd1073741824;
      end
      rom[k] = SINE_MAG_W'(((longint'(sum) * 32767) + 536870912) >> 30);
    end
    return rom;
  endfunction

  // phase in turns to table address and sign
  function automatic sin_addr_t sin_lookup(input logic [PHASE_W-1:0] phase);
    sin_addr_t                 res;
    logic [SINE_DEPTH_LOG-1:0] idx;
    idx      = phase[PHASE_W-3 -: SINE_DEPTH_LOG];
    res.neg  = phase[PHASE_W-1];
    res.addr = phase[PHASE_W-2] ? (SINE_ADDR_W'(SINE_DEPTH) - SINE_ADDR_W'(idx))
                                : SINE_ADDR_W'(idx);
    return res;
  endfunction

endpackage

@@ rtl/core/shimmer_highlight_pixel_core.sv @@
// shimmer highlight for one rgba pixel per clock, fully pipelined
// done_o rises with the result registers, after the input register,
//   36 divider stages for u and v, then 10 stages of products, sine and lift
// throughput: one pixel every cycle, busy_o stays low, results cannot be stalled
// reset: clears the valid chain and sets width 256, height 256, time 0
// config writes take effect for the next pixel and also for pixels already in flight
`timescale 1ns / 1ps

module shimmer_highlight_pixel_core import shimmer_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic [7:0]            alpha_in_i,
  input  logic [COORD_BITS-1:0] column_i,
  input  logic [COORD_BITS-1:0] row_pos_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i,
  output logic                  done_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [K_W-1:0] K_COORD [3] = '{K_U450, K_U190, K_V30};
  localparam int POS_R1 = DIV_W + 5;
  localparam int POS_P3 = DIV_W + 9;

  // configuration registers
  logic [DEN_W-1:0]  frame_width_q;
  logic [DEN_W-1:0]  frame_height_q;
  logic [TIME_W-1:0] time_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DEN_W'(256);
      frame_height_q <= DEN_W'(256);
      time_value_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          frame_width_q <= (cfg_wdata_i[DEN_W-1:0] == '0) ? DEN_W'(1)
                                                          : cfg_wdata_i[DEN_W-1:0];
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_q <= (cfg_wdata_i[DEN_W-1:0] == '0) ? DEN_W'(1)
                                                           : cfg_wdata_i[DEN_W-1:0];
        end
        CFG_TIME_VALUE: begin
          time_value_q <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // time terms, free running from the time register
  // ---------------------------------------------------------------------------
  logic [63:0]              t6_pp_q;
  logic [TIME_W+K_SPLIT-1:0] t700_lo_q, t700_hi_q, t1080_lo_q, t1080_hi_q;
  logic [47:0]              t700_full, t1080_full;
  logic [PHASE_W-1:0]       tt6_q, tt700_q, tt1080_q;
  sin_addr_t                s6_addr;
  logic [SINE_MAG_W-1:0]    s6_mag_q;
  logic                     s6_neg_q;
  logic signed [15:0]       s6;
  logic signed [36:0]       s180_lo_q, s180_hi_q;
  logic [46:0]              s180_full;
  logic [PHASE_W-1:0]       s180_q;

  assign t700_full  = t700_lo_q[47:0] + {t700_hi_q[27:0], {K_SPLIT{1'b0}}};
  assign t1080_full = t1080_lo_q[47:0] + {t1080_hi_q[27:0], {K_SPLIT{1'b0}}};
  assign s6_addr    = sin_lookup(tt6_q);
  assign s6         = s6_neg_q ? -$signed(16'(s6_mag_q)) : $signed(16'(s6_mag_q));
  assign s180_full  = {{10{s180_lo_q[36]}}, s180_lo_q} + {s180_hi_q[26:0], {K_SPLIT{1'b0}}};

  always_ff @(posedge clk_i) begin
    // partial products of t with the time coefficients
    t6_pp_q    <= 64'(time_value_q) * 64'(K_T6[31:0]);
    t700_lo_q  <= (TIME_W+K_SPLIT)'(time_value_q) * (TIME_W+K_SPLIT)'(K_T700[K_SPLIT-1:0]);
    t700_hi_q  <= (TIME_W+K_SPLIT)'(time_value_q) * (TIME_W+K_SPLIT)'(K_T700[K_W-1:K_SPLIT]);
    t1080_lo_q <= (TIME_W+K_SPLIT)'(time_value_q) * (TIME_W+K_SPLIT)'(K_T1080[K_SPLIT-1:0]);
    t1080_hi_q <= (TIME_W+K_SPLIT)'(time_value_q) * (TIME_W+K_SPLIT)'(K_T1080[K_W-1:K_SPLIT]);
    // phases in turns
    tt6_q      <= t6_pp_q[47:24];
    tt700_q    <= t700_full[47:24];
    tt1080_q   <= t1080_full[47:24];
    // sin(6t)
    s6_mag_q   <= SINE_ROM[s6_addr.addr];
    s6_neg_q   <= s6_addr.neg;
    // 180 * sin(6t)
    s180_lo_q  <= s6 * $signed({1'b0, K_S180[K_SPLIT-1:0]});
    s180_hi_q  <= s6 * $signed({1'b0, K_S180[K_W-1:K_SPLIT]});
    s180_q     <= s180_full[46:23];
  end

  // ---------------------------------------------------------------------------
  // input beat and the pixel / valid chain
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [COORD_BITS-1:0] col_q, row_q;
  pix_t                  pix_q [PIPE_LAT];
  logic                  vld_q [PIPE_LAT];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    col_q    <= column_i;
    row_q    <= row_pos_i;
    pix_q[0] <= '{red: red_in_i, green: green_in_i, blue: blue_in_i, alpha: alpha_in_i};
    for (int k = 1; k < PIPE_LAT; k++) begin
      pix_q[k] <= pix_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k < PIPE_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // u = column / width, v = row / height, Q24
  logic [DIV_W-1:0] u_quo, v_quo;

  shimmer_div u_div_u (
    .clk_i (clk_i),
    .num_i (col_q),
    .den_i (frame_width_q),
    .quo_o (u_quo)
  );

  shimmer_div u_div_v (
    .clk_i (clk_i),
    .num_i (row_q),
    .den_i (frame_height_q),
    .quo_o (v_quo)
  );

  // ---------------------------------------------------------------------------
  // coordinate terms 450u, 190u, 30v
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]   cq   [3];
  logic [PP_W-1:0]    q_lo [3];
  logic [PP_W-1:0]    q_hi [3];
  logic [PP_W-1:0]    k_lo [3];
  logic [PP_W-1:0]    k_hi [3];
  logic [PP_W-1:0]    pp_d [3][4];
  logic [PP_W-1:0]    pp_q [3][4];
  logic [CPROD_W-1:0] cs_lo_q [3];
  logic [CPROD_W-1:0] cs_hi_q [3];
  logic [CPROD_W-1:0] csum    [3];
  logic [PHASE_W-1:0] cterm_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cq[j]      = (j == 2) ? v_quo : u_quo;
      q_lo[j]    = PP_W'(cq[j][U_LO_W-1:0]);
      q_hi[j]    = PP_W'(cq[j][DIV_W-1:U_LO_W]);
      k_lo[j]    = PP_W'(K_COORD[j][K_SPLIT-1:0]);
      k_hi[j]    = PP_W'(K_COORD[j][K_W-1:K_SPLIT]);
      pp_d[j][0] = q_lo[j] * k_lo[j];
      pp_d[j][1] = q_lo[j] * k_hi[j];
      pp_d[j][2] = q_hi[j] * k_lo[j];
      pp_d[j][3] = q_hi[j] * k_hi[j];
      csum[j]    = cs_lo_q[j] + cs_hi_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      for (int p = 0; p < 4; p++) begin
        pp_q[j][p] <= pp_d[j][p];
      end
      cs_lo_q[j] <= CPROD_W'(pp_q[j][0]) + CPROD_W'({pp_q[j][1], {K_SPLIT{1'b0}}});
      cs_hi_q[j] <= CPROD_W'({pp_q[j][2], {U_LO_W{1'b0}}})
                  + CPROD_W'({pp_q[j][3], {(U_LO_W + K_SPLIT){1'b0}}});
      cterm_q[j] <= csum[j][CPROD_W-1 -: PHASE_W];
    end
  end

  // ---------------------------------------------------------------------------
  // phases, sines and the shimmer factor
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]       ph_a_q, ph_b_q;
  sin_addr_t                sa_addr, sb_addr;
  logic [SINE_MAG_W-1:0]    mag_a_q, mag_b_q;
  logic                     neg_a_q, neg_b_q;
  logic signed [FAC_W-1:0]  sin_a, sin_b, fac_d;
  logic signed [FAC_W-1:0]  fac_q, fac1_q;

  assign sa_addr = sin_lookup(ph_a_q);
  assign sb_addr = sin_lookup(ph_b_q);
  assign sin_a   = neg_a_q ? -$signed(FAC_W'(mag_a_q)) : $signed(FAC_W'(mag_a_q));
  assign sin_b   = neg_b_q ? -$signed(FAC_W'(mag_b_q)) : $signed(FAC_W'(mag_b_q));
  assign fac_d   = $signed(FAC_W'(FAC_OFFSET)) + sin_a - sin_b;

  always_ff @(posedge clk_i) begin
    ph_a_q  <= cterm_q[0] + s180_q - tt700_q;
    ph_b_q  <= cterm_q[1] + cterm_q[2] + tt1080_q;
    mag_a_q <= SINE_ROM[sa_addr.addr];
    mag_b_q <= SINE_ROM[sb_addr.addr];
    neg_a_q <= sa_addr.neg;
    neg_b_q <= sb_addr.neg;
    fac_q   <= fac_d;
    fac1_q  <= fac_q;
  end

  // ---------------------------------------------------------------------------
  // channel lift: c + floor((255 - c) * max * fac / (255 * 2^16)) when positive
  // ---------------------------------------------------------------------------
  logic [7:0]         chan_r1 [3];
  logic [7:0]         chan_p3 [3];
  logic [7:0]         mx_r1;
  logic [7:0]         inv_q   [3];
  logic [7:0]         m_q;
  logic [15:0]        a_q     [3];
  logic signed [34:0] n_q     [3];
  logic [34:0]        qprod   [3];
  logic [8:0]         q_q     [3];
  logic               pos_q   [3];
  logic [9:0]         lift    [3];
  logic [7:0]         res     [3];

  always_comb begin
    chan_r1[0] = pix_q[POS_R1].red;
    chan_r1[1] = pix_q[POS_R1].green;
    chan_r1[2] = pix_q[POS_R1].blue;
    chan_p3[0] = pix_q[POS_P3].red;
    chan_p3[1] = pix_q[POS_P3].green;
    chan_p3[2] = pix_q[POS_P3].blue;
    mx_r1      = (chan_r1[0] > chan_r1[1]) ? chan_r1[0] : chan_r1[1];
    if (chan_r1[2] > mx_r1) begin
      mx_r1 = chan_r1[2];
    end
    for (int i = 0; i < 3; i++) begin
      qprod[i] = 35'(n_q[i][32:16]) * 35'(RECIP_255);
      lift[i]  = {2'b00, chan_p3[i]} + {1'b0, q_q[i]};
      if (!pos_q[i]) begin
        res[i] = chan_p3[i];
      end else if (lift[i] > 10'd255) begin
        res[i] = 8'd255;
      end else begin
        res[i] = lift[i][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= mx_r1;
    for (int i = 0; i < 3; i++) begin
      inv_q[i] <= 8'd255 - chan_r1[i];
      a_q[i]   <= 16'(inv_q[i]) * 16'(m_q);
      n_q[i]   <= $signed({1'b0, a_q[i]}) * fac1_q;
      pos_q[i] <= !n_q[i][34] && (n_q[i] != '0);
      q_q[i]   <= qprod[i][RECIP_SHIFT+8:RECIP_SHIFT];
    end
  end

  // result registers, one beat per cycle
  logic       done_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[POS_P3];
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= res[0];
    green_q <= res[1];
    blue_q  <= res[2];
    alpha_q <= pix_q[POS_P3].alpha;
  end

  assign done_o      = done_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;

`ifndef SYNTHESIS
  // every accepted beat is followed by a result strobe
  a_beat_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(PIPE_LAT + 1) done_o)
    else $error("result strobe missing after accepted beat");

  // alpha travels unchanged with its pixel
  a_alpha_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(PIPE_LAT + 1)
      (alpha_out_o == $past(alpha_in_i, PIPE_LAT + 1)))
    else $error("alpha does not match its pixel");

  // the highlight never darkens a channel
  a_no_darken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(PIPE_LAT + 1)
      ((red_out_o >= $past(red_in_i, PIPE_LAT + 1)) &&
       (green_out_o >= $past(green_in_i, PIPE_LAT + 1)) &&
       (blue_out_o >= $past(blue_in_i, PIPE_LAT + 1))))
    else $error("output channel below input channel");
`endif

endmodule

@@ rtl/core/shimmer_div.sv @@
// pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage
`timescale 1ns / 1ps

module shimmer_div import shimmer_pkg::*; (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [DIV_W-1:0]      quo_o
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] num;
  } div_st_t;

  div_st_t          st_src [DIV_W];
  div_st_t          st_d   [DIV_W];
  div_st_t          st_q   [DIV_W];
  logic [DEN_W:0]   trial  [DIV_W];
  logic             ge     [DIV_W];

  // stage inputs: the first stage starts from the numerator
  always_comb begin
    st_src[0].rem = '0;
    st_src[0].quo = '0;
    st_src[0].num = {num_i, {FRAC_BITS{1'b0}}};
    for (int k = 1; k < DIV_W; k++) begin
      st_src[k] = st_q[k-1];
    end
  end

  // one shift-subtract step per stage
  always_comb begin
    for (int k = 0; k < DIV_W; k++) begin
      trial[k]     = {st_src[k].rem, st_src[k].num[DIV_W-1]};
      ge[k]        = trial[k] >= {1'b0, den_i};
      st_d[k].rem  = ge[k] ? DEN_W'(trial[k] - {1'b0, den_i}) : trial[k][DEN_W-1:0];
      st_d[k].quo  = {st_src[k].quo[DIV_W-2:0], ge[k]};
      st_d[k].num  = {st_src[k].num[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_W; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign quo_o = st_q[DIV_W-1].quo;

endmodule

@@ tb/tb_shimmer_highlight_pixel_core.sv @@
// testbench of the shimmer highlight pixel core: queued pixels, golden predictor, strobe checks
`timescale 1ns / 1ps

module tb_shimmer_highlight_pixel_core;
  import shimmer_pkg::*;

  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
  localparam int         DRAIN_CYCLES  = 60;
  localparam longint     LIFT_DIV      = 64'd16711680;

  typedef struct {
    pix_t                  px;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pixel_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [7:0]            red_in_i = '0;
  logic [7:0]            green_in_i = '0;
  logic [7:0]            blue_in_i = '0;
  logic [7:0]            alpha_in_i = '0;
  logic [COORD_BITS-1:0] column_i = '0;
  logic [COORD_BITS-1:0] row_pos_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = '0;
  logic [TIME_W-1:0]     cfg_wdata_i = '0;
  logic                  done_o;
  logic [7:0]            red_out_o;
  logic [7:0]            green_out_o;
  logic [7:0]            blue_out_o;
  logic [7:0]            alpha_out_o;

  shimmer_highlight_pixel_core dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // golden copy of the registers and the quarter-wave table
  logic [12:0]   gold_width = 13'd256;
  logic [12:0]   gold_height = 13'd256;
  logic [31:0]   gold_time = '0;
  int            quarter_sine [SINE_DEPTH+1];

  pixel_req_t    pending_pixels [$];
  pix_t          expected_pixels [$];
  int            sender_idle_pct = 0;
  int            mismatches = 0;

  // quarter-wave sine magnitudes from a 7-term series in q30
  task automatic fill_quarter_sine();
    logic [63:0] x, x2, term;
    longint      acc;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (64'(k) * 64'd1686629713) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      quarter_sine[k] = int'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
    end
  endtask

  function automatic int sine_of_turns(logic [23:0] ph);
    int idx;
    int mag;
    idx = int'(ph[21:12]);
    mag = ph[22] ? quarter_sine[SINE_DEPTH - idx] : quarter_sine[idx];
    return ph[23] ? -mag : mag;
  endfunction

  function automatic logic [23:0] time_turns(logic [39:0] k);
    logic [63:0] p;
    p = 64'(gold_time) * 64'(k);
    return p[47:24];
  endfunction

  function automatic logic [23:0] coord_turns(logic [63:0] frac, logic [39:0] k);
    logic [63:0] p;
    p = frac * 64'(k);
    return p[55:32];
  endfunction

  function automatic logic [7:0] lift(logic [7:0] c, logic [7:0] m, int fac);
    longint n;
    longint r;
    n = longint'(255 - int'(c)) * longint'(m) * longint'(fac);
    if (n <= 0) return c;
    r = longint'(c) + n / LIFT_DIV;
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  // expected highlighted pixel for one request
  function automatic pix_t shimmer_pixel(pixel_req_t rq);
    logic [63:0] w, h, u, v, s_ext, sp;
    logic [23:0] ph_a, ph_b;
    int          s6, fac;
    logic [7:0]  m;
    pix_t        res;
    w     = (gold_width == 0) ? 64'd1 : 64'(gold_width);
    h     = (gold_height == 0) ? 64'd1 : 64'(gold_height);
    u     = (64'(rq.col) << 24) / w;
    v     = (64'(rq.row) << 24) / h;
    s6    = sine_of_turns(time_turns(K_T6));
    s_ext = 64'(longint'(s6));
    sp    = s_ext * 64'(K_S180);
    ph_a  = coord_turns(u, K_U450) + sp[46:23] - time_turns(K_T700);
    ph_b  = coord_turns(u, K_U190) + coord_turns(v, K_V30) + time_turns(K_T1080);
    fac   = FAC_OFFSET + sine_of_turns(ph_a) - sine_of_turns(ph_b);
    m     = rq.px.red > rq.px.green ? rq.px.red : rq.px.green;
    if (rq.px.blue > m) m = rq.px.blue;
    res.red   = lift(rq.px.red, m, fac);
    res.green = lift(rq.px.green, m, fac);
    res.blue  = lift(rq.px.blue, m, fac);
    res.alpha = rq.px.alpha;
    return res;
  endfunction

  // driver: take the accepted beat, then offer the next pending pixel or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      pixel_req_t rq;
      if (start_i && !busy_o) begin
        rq.px  = '{red_in_i, green_in_i, blue_in_i, alpha_in_i};
        rq.col = column_i;
        rq.row = row_pos_i;
        expected_pixels.push_back(shimmer_pixel(rq));
      end
      if ((!start_i || !busy_o) && pending_pixels.size() > 0
          && $urandom_range(99) >= sender_idle_pct) begin
        rq = pending_pixels.pop_front();
        start_i    <= 1'b1;
        red_in_i   <= rq.px.red;
        green_in_i <= rq.px.green;
        blue_in_i  <= rq.px.blue;
        alpha_in_i <= rq.px.alpha;
        column_i   <= rq.col;
        row_pos_i  <= rq.row;
      end else if (!start_i || !busy_o) begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      pix_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h %h %h %h",
                                       red_out_o, green_out_o, blue_out_o, alpha_out_o);
      end else begin
        want = expected_pixels.pop_front();
        if (want.red !== red_out_o || want.green !== green_out_o ||
            want.blue !== blue_out_o || want.alpha !== alpha_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch rgba exp %h %h %h %h got %h %h %h %h",
                     want.red, want.green, want.blue, want.alpha,
                     red_out_o, green_out_o, blue_out_o, alpha_out_o);
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:  gold_width = data[12:0];
      CFG_FRAME_HEIGHT: gold_height = data[12:0];
      CFG_TIME_VALUE:   gold_time = data;
      default: ;
    endcase
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] t);
    reg_write(CFG_FRAME_WIDTH, w);
    reg_write(CFG_FRAME_HEIGHT, h);
    reg_write(CFG_TIME_VALUE, t);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || start_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_pixel(logic [31:0] rgba, logic [11:0] col, logic [11:0] row);
    pixel_req_t rq;
    rq.px  = rgba;
    rq.col = col;
    rq.row = row;
    pending_pixels.push_back(rq);
  endtask

  // random pixels, mostly inside the frame when both sizes are at most 4096
  task automatic queue_random(int count);
    int w, h;
    w = (gold_width == 0) ? 1 : int'(gold_width);
    h = (gold_height == 0) ? 1 : int'(gold_height);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8 && w <= 4096 && h <= 4096)
        queue_pixel($urandom(), 12'($urandom_range(w - 1)), 12'($urandom_range(h - 1)));
      else
        queue_pixel($urandom(), 12'($urandom()), 12'($urandom()));
    end
  endtask

  int idle_plan [4] = '{0, 76, 0, 22};

  // stimulus phases
  initial begin
    fill_quarter_sine();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels at reset settings
    queue_pixel(32'h00000000, 12'd0, 12'd0);
    queue_pixel(32'hFFFFFFFF, 12'd255, 12'd255);
    queue_pixel(32'hFF000080, 12'd10, 12'd20);
    queue_pixel(32'h00FF0001, 12'd128, 12'd64);
    queue_pixel(32'h0000FFFE, 12'd200, 12'd3);
    queue_pixel(32'h80808080, 12'd4095, 12'd4095);
    queue_pixel(32'h01010101, 12'd256, 12'd0);
    queue_pixel(32'hFEFEFE00, 12'd0, 12'd4095);
    queue_pixel(32'h55AA5533, 12'd4095, 12'd0);
    queue_pixel(32'hAA55AACC, 12'd77, 12'd199);
    queue_pixel(32'h10F0207F, 12'd31, 12'd255);
    queue_pixel(32'hFF00FF00, 12'd255, 12'd128);
    wait_drained();

    // extremes of the frame registers, zero sizes, oversized and the spare index
    set_frame(32'd1, 32'd1, 32'hFFFFFFFF);
    queue_pixel(32'hC0804020, 12'd0, 12'd0);
    queue_pixel(32'hC0804020, 12'd4095, 12'd4095);
    queue_pixel(32'h7F7F7F7F, 12'd1, 12'd2);
    wait_drained();
    set_frame(32'hFFFFE000, 32'd0, 32'd0);
    reg_write(CFG_SPARE_IDX, 32'hFFFFFFFF);
    cfg_we_i <= 1'b0;
    queue_pixel(32'hFFFFFFFF, 12'd4095, 12'd0);
    queue_pixel(32'h20406080, 12'd3, 12'd4095);
    queue_random(20);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_frame(32'd4096, 32'd4096, $urandom());
        1: set_frame(32'd8191, 32'd1, $urandom());
        2: set_frame(32'($urandom_range(4096, 1)), 32'($urandom_range(64, 1)), $urandom());
        default: set_frame(32'($urandom_range(640, 2)), 32'($urandom_range(480, 2)),
                           32'($urandom_range(32'h0004_0000)));
      endcase
      sender_idle_pct = idle_plan[ph % 4];
      queue_random(200);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS shimmer_highlight_pixel_core");
    end else begin
      $display("FAIL shimmer_highlight_pixel_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL shimmer_highlight_pixel_core");
    $finish;
  end

endmodule
